// ===== rtl/n2r_pkg.sv =====
package n2r_pkg;

   // Line geometry
   localparam int MAX_ROW_WIDTH = 4096;
   localparam int LINE_DEPTH    = MAX_ROW_WIDTH / 2;
   localparam int COL_W         = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int PAIRS_W       = $clog2(LINE_DEPTH + 1);

   // Configuration registers
   localparam int ROW_WIDTH_W = 13;
   localparam int ORDER_W     = 2;
   localparam int REG_INDEX_W = 1;
   localparam int CSR_DATA_W  = ROW_WIDTH_W;

   localparam logic [REG_INDEX_W-1:0] REG_ROW_WIDTH    = 1'b0;
   localparam logic [REG_INDEX_W-1:0] REG_OUTPUT_ORDER = 1'b1;

   localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 13'd640;

   localparam logic [ORDER_W-1:0] ORDER_BGRA = 2'd0;
   localparam logic [ORDER_W-1:0] ORDER_RGB  = 2'd1;
   localparam logic [ORDER_W-1:0] ORDER_RGBA = 2'd2;

   // Result format
   localparam int PIXEL_W      = 64;
   localparam int BYTE_COUNT_W = 4;
   localparam logic [BYTE_COUNT_W-1:0] BYTES_RGB  = 4'd6;
   localparam logic [BYTE_COUNT_W-1:0] BYTES_FULL = 4'd8;

   // Queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

   // One pair of pixels with its resolved chroma
   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] luma_second;
      logic [7:0] chroma_v;
      logic [7:0] chroma_u;
   } pair_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // Pairs in one row: width capped, halved, at least one
   function automatic logic [PAIRS_W-1:0] pairs_per_row(input logic [ROW_WIDTH_W-1:0] width);
      logic [31:0] capped;
      logic [PAIRS_W-1:0] pairs;
      capped = {{(32-ROW_WIDTH_W){1'b0}}, width};
      if (capped > 32'(MAX_ROW_WIDTH)) begin
         capped = 32'(MAX_ROW_WIDTH);
      end
      pairs = capped[PAIRS_W:1];
      if (pairs == '0) begin
         pairs = PAIRS_W'(1);
      end
      return pairs;
   endfunction

endpackage

// ===== rtl/n2r_front.sv =====
module n2r_front (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  n2r_pkg::pair_type                in_data,
   input  logic                             in_frame_start,
   input  logic [n2r_pkg::ROW_WIDTH_W-1:0]  row_width,
   output logic                             out_valid,
   input  logic                             out_ready,
   output n2r_pkg::pair_type                out_data
);
   import n2r_pkg::*;

   logic [15:0]         line_mem [LINE_DEPTH];
   logic [15:0]         line_rd_ff;
   logic [COL_W-1:0]    col_ff, col_in;
   logic                odd_ff, odd_in;
   logic                valid_ff, valid_in;
   logic                item_odd_ff;
   pair_type            item_ff;
   logic                accept;
   logic [COL_W-1:0]    col_cur;
   logic                odd_cur;
   logic [PAIRS_W-1:0]  col_next;
   logic                row_end;

   assign in_ready = !valid_ff || out_ready;
   assign accept   = in_valid && in_ready;

   // Position of this pair, restarted at frame start
   always_comb begin
      col_cur  = in_frame_start ? '0 : col_ff;
      odd_cur  = in_frame_start ? 1'b0 : odd_ff;
      col_next = PAIRS_W'(col_cur) + PAIRS_W'(1);
      row_end  = col_next >= pairs_per_row(row_width);
      col_in   = col_ff;
      odd_in   = odd_ff;
      valid_in = valid_ff;
      if (accept) begin
         col_in   = row_end ? '0 : col_next[COL_W-1:0];
         odd_in   = odd_cur ^ row_end;
         valid_in = 1'b1;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         odd_ff   <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         col_ff   <= col_in;
         odd_ff   <= odd_in;
         valid_ff <= valid_in;
      end
   end

   // Store chroma on even rows, fetch it back on odd rows
   always_ff @(posedge clock) begin
      if (accept && !odd_cur) begin
         line_mem[col_cur] <= {in_data.chroma_v, in_data.chroma_u};
      end
      if (accept && odd_cur) begin
         line_rd_ff <= line_mem[col_cur];
      end
   end

   // Hold the item until the queue takes it
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff     <= in_data;
         item_odd_ff <= odd_cur;
      end
   end

   always_comb begin
      out_data = item_ff;
      if (item_odd_ff) begin
         out_data.chroma_v = line_rd_ff[15:8];
         out_data.chroma_u = line_rd_ff[7:0];
      end
   end

   assign out_valid = valid_ff;

endmodule

// ===== rtl/n2r_queue.sv =====
module n2r_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  n2r_pkg::pair_type          in_data,
   output logic                       out_valid,
   input  logic                       out_ready,
   output n2r_pkg::pair_type          out_data,
   output n2r_pkg::queue_status_type  status
);
   import n2r_pkg::*;

   pair_type                slot_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]    count_ff, count_in;
   logic                    push;
   logic                    pop;

   assign status.full  = count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH);
   assign status.empty = count_ff == '0;
   assign in_ready     = !status.full;
   assign out_valid    = !status.empty;
   assign push         = in_valid && in_ready;
   assign pop          = out_valid && out_ready;
   assign out_data     = slot_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (QUEUE_PTR_W+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (QUEUE_PTR_W+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

// ===== rtl/n2r_back.sv =====
module n2r_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               in_valid,
   output logic                               in_ready,
   input  n2r_pkg::pair_type                  in_data,
   input  logic [n2r_pkg::ORDER_W-1:0]        output_order,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [n2r_pkg::PIXEL_W-1:0]        rsp_pixel_bytes,
   output logic [n2r_pkg::BYTE_COUNT_W-1:0]   rsp_byte_count
);
   import n2r_pkg::*;

   localparam int SUM_W = 20;
   localparam logic signed [SUM_W-1:0] COEF_Y    = 20'sd298;
   localparam logic signed [SUM_W-1:0] COEF_UB   = 20'sd517;
   localparam logic signed [SUM_W-1:0] COEF_UG   = 20'sd100;
   localparam logic signed [SUM_W-1:0] COEF_VG   = 20'sd208;
   localparam logic signed [SUM_W-1:0] COEF_VR   = 20'sd409;
   localparam logic signed [SUM_W-1:0] OFFSET_Y  = 20'sd16;
   localparam logic signed [SUM_W-1:0] OFFSET_UV = 20'sd128;
   localparam logic [7:0]              ALPHA     = 8'd255;

   // Clamp a scaled sum to one byte, truncating the fraction
   function automatic logic [7:0] channel(input logic signed [SUM_W-1:0] sum);
      logic [7:0] value;
      if (sum[SUM_W-1]) begin
         value = 8'd0;
      end else if (|sum[SUM_W-2:16]) begin
         value = 8'hFF;
      end else begin
         value = sum[15:8];
      end
      return value;
   endfunction

   logic                     advance;
   logic                     prod_valid_ff, prod_valid_in;
   logic                     out_valid_ff, out_valid_in;
   logic signed [SUM_W-1:0]  t1_ff, t2_ff, ub_ff, uvg_ff, vr_ff;
   logic signed [SUM_W-1:0]  y1, y2, u, v;
   logic [PIXEL_W-1:0]       pixel_ff, pixel_in;
   logic [BYTE_COUNT_W-1:0]  count_ff, count_in;
   logic [7:0]               r1, g1, b1, r2, g2, b2;

   assign advance   = !out_valid_ff || rsp_ready;
   assign in_ready  = advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_pixel_bytes = pixel_ff;
   assign rsp_byte_count  = count_ff;

   // Stage one: centered samples times constant coefficients
   always_comb begin
      y1 = $signed({{(SUM_W-8){1'b0}}, in_data.luma_first}) - OFFSET_Y;
      y2 = $signed({{(SUM_W-8){1'b0}}, in_data.luma_second}) - OFFSET_Y;
      u  = $signed({{(SUM_W-8){1'b0}}, in_data.chroma_u}) - OFFSET_UV;
      v  = $signed({{(SUM_W-8){1'b0}}, in_data.chroma_v}) - OFFSET_UV;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         t1_ff  <= y1 * COEF_Y;
         t2_ff  <= y2 * COEF_Y;
         ub_ff  <= u * COEF_UB;
         uvg_ff <= -(u * COEF_UG) - v * COEF_VG;
         vr_ff  <= v * COEF_VR;
      end
   end

   // Stage two: sums, clamp and byte order
   always_comb begin
      r1 = channel(t1_ff + vr_ff);
      g1 = channel(t1_ff + uvg_ff);
      b1 = channel(t1_ff + ub_ff);
      r2 = channel(t2_ff + vr_ff);
      g2 = channel(t2_ff + uvg_ff);
      b2 = channel(t2_ff + ub_ff);
      case (output_order)
         ORDER_BGRA: begin
            pixel_in = {ALPHA, r2, g2, b2, ALPHA, r1, g1, b1};
            count_in = BYTES_FULL;
         end
         ORDER_RGB: begin
            pixel_in = {16'd0, b2, g2, r2, b1, g1, r1};
            count_in = BYTES_RGB;
         end
         default: begin
            pixel_in = {ALPHA, b2, g2, r2, ALPHA, b1, g1, r1};
            count_in = BYTES_FULL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pixel_ff <= pixel_in;
         count_ff <= count_in;
      end
   end

   // Valid bits move with the stages, which all hold while the output stalls
   always_comb begin
      prod_valid_in = prod_valid_ff;
      out_valid_in  = out_valid_ff;
      if (advance) begin
         prod_valid_in = in_valid;
         out_valid_in  = prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

endmodule

// ===== rtl/nv21_to_rgb_converter.sv =====
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata: luma_first, luma_second, chroma_v,
//                                            chroma_u; tuser: frame_start
// rsp      out        rsp_tvalid/rsp_tready  tdata: pixel_bytes, byte_count
// csr      in         csr_we                 csr_addr: register index, csr_wdata
//
// One item per clock sustained while rsp is not stalled; each result passes the
// line buffer stage, queue, product stage, and clamp and pack stage in order.
// The line buffer gives one write or one read per item, which sets the rate.
// Reset is synchronous and clears position, queue and valid bits; the line
// buffer holds no reset value and needs no clearing pass.
// A stall on rsp fills the back stages and the queue before req_tready drops.
module nv21_to_rgb_converter (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // luma_first, luma_second,
                                                          // chroma_v, chroma_u
   input  logic                               req_tuser,  // frame_start
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [71:0]                        rsp_tdata,  // pixel_bytes, byte_count,
                                                          // 4 zero bits
   input  logic                               csr_we,
   input  logic [n2r_pkg::REG_INDEX_W-1:0]    csr_addr,
   input  logic [n2r_pkg::CSR_DATA_W-1:0]     csr_wdata
);
   import n2r_pkg::*;

   logic [ROW_WIDTH_W-1:0]   row_width_ff, row_width_in;
   logic [ORDER_W-1:0]       order_ff, order_in;
   pair_type                 req_pair;
   pair_type                 front_data;
   pair_type                 queue_data;
   logic                     front_valid, front_ready;
   logic                     queue_valid, queue_ready;
   queue_status_type         queue_status;
   logic [PIXEL_W-1:0]       pixel_bytes;
   logic [BYTE_COUNT_W-1:0]  byte_count;
   logic                     queue_push, queue_pop;

   // Configuration writes
   always_comb begin
      row_width_in = row_width_ff;
      order_in     = order_ff;
      if (csr_we) begin
         unique case (csr_addr)
            REG_ROW_WIDTH:    row_width_in = csr_wdata[ROW_WIDTH_W-1:0];
            REG_OUTPUT_ORDER: order_in     = csr_wdata[ORDER_W-1:0];
            default:          ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= ROW_WIDTH_RESET;
         order_ff     <= ORDER_BGRA;
      end else begin
         row_width_ff <= row_width_in;
         order_ff     <= order_in;
      end
   end

   // Unpack the item fields, first field in the low byte
   always_comb begin
      req_pair.luma_first  = req_tdata[7:0];
      req_pair.luma_second = req_tdata[15:8];
      req_pair.chroma_v    = req_tdata[23:16];
      req_pair.chroma_u    = req_tdata[31:24];
   end

   n2r_front u_front (
      .clock          (clock),
      .reset          (reset),
      .in_valid       (req_tvalid),
      .in_ready       (req_tready),
      .in_data        (req_pair),
      .in_frame_start (req_tuser),
      .row_width      (row_width_ff),
      .out_valid      (front_valid),
      .out_ready      (front_ready),
      .out_data       (front_data)
   );

   n2r_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_data   (front_data),
      .out_valid (queue_valid),
      .out_ready (queue_ready),
      .out_data  (queue_data),
      .status    (queue_status)
   );

   n2r_back u_back (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (queue_valid),
      .in_ready        (queue_ready),
      .in_data         (queue_data),
      .output_order    (order_ff),
      .rsp_valid       (rsp_tvalid),
      .rsp_ready       (rsp_tready),
      .rsp_pixel_bytes (pixel_bytes),
      .rsp_byte_count  (byte_count)
   );

   assign rsp_tdata  = {4'd0, byte_count, pixel_bytes};
   assign queue_push = front_valid && front_ready;
   assign queue_pop  = queue_valid && queue_ready;

   // Queue never takes an item while full, never gives one while empty
   assert property (@(posedge clock) disable iff (reset)
      queue_push |-> !queue_status.full)
      else $error("queue push while full");

   assert property (@(posedge clock) disable iff (reset)
      queue_pop |-> !queue_status.empty)
      else $error("queue pop while empty");

   // A three-byte-per-pixel result leaves the top two bytes clear
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && byte_count == BYTES_RGB) |-> pixel_bytes[63:48] == 16'd0)
      else $error("unused bytes not zero in RGB order");

endmodule

// ===== test/nv21_checker.sv =====
`timescale 1ns / 1ps

// Watches the pair and pixel channels, predicts each pixel pair from its own
// copy of position, line buffer and registers, and compares in arrival order.
module nv21_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   input  logic                               req_tready,
   input  logic [31:0]                        req_tdata,  // luma_first, luma_second,
                                                          // chroma_v, chroma_u
   input  logic                               req_tuser,  // frame_start
   input  logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   input  logic [71:0]                        rsp_tdata,  // pixel_bytes, byte_count,
                                                          // 4 zero bits
   input  logic                               csr_we,
   input  logic [n2r_pkg::REG_INDEX_W-1:0]    csr_addr,
   input  logic [n2r_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output int                                 mismatch_count,
   output int                                 outstanding
);

   import n2r_pkg::*;

   localparam int MAX_REPORTS = 40;

   typedef struct packed {
      logic [PIXEL_W-1:0]      pixels;
      logic [BYTE_COUNT_W-1:0] byte_count;
   } rgb_word_type;

   rgb_word_type            expected_words[$];
   logic [15:0]             chroma_line[LINE_DEPTH];
   logic [ROW_WIDTH_W-1:0]  row_width;
   logic [ORDER_W-1:0]      out_order;
   int                      pair_col;
   logic                    odd_row;
   int                      fails = 0;
   int                      waiting = 0;

   assign mismatch_count = fails;
   assign outstanding    = waiting;

   task automatic report_mismatch(input string what);
      fails++;
      if (fails <= MAX_REPORTS) begin
         $display("%0t ns: mismatch: %s", $time, what);
      end
   endtask

   // Pairs per row: cap at the line size, halve, keep at least one
   function automatic int row_pairs(input logic [ROW_WIDTH_W-1:0] width);
      int pairs;
      pairs = (int'(width) > MAX_ROW_WIDTH) ? MAX_ROW_WIDTH / 2 : int'(width) / 2;
      return (pairs == 0) ? 1 : pairs;
   endfunction

   // Scale down truncating toward zero, then clamp to a byte
   function automatic logic [7:0] clamp_channel(input int sum);
      int scaled;
      if (sum < 0) begin
         return 8'd0;
      end
      scaled = sum / 256;
      return (scaled > 255) ? 8'd255 : scaled[7:0];
   endfunction

   // Convert one luma pair with its chroma and pack it in the selected order
   function automatic rgb_word_type convert_pair(input logic [7:0] y_left,
                                                 input logic [7:0] y_right,
                                                 input logic [7:0] v_raw,
                                                 input logic [7:0] u_raw,
                                                 input logic [ORDER_W-1:0] order);
      int v, u, t_left, t_right, blue_term, green_term, red_term;
      logic [7:0] r1, g1, b1, r2, g2, b2;
      rgb_word_type word;
      v          = int'(v_raw) - 128;
      u          = int'(u_raw) - 128;
      blue_term  = u * 517;
      green_term = -u * 100 - v * 208;
      red_term   = v * 409;
      t_left     = (int'(y_left) - 16) * 298;
      t_right    = (int'(y_right) - 16) * 298;
      r1 = clamp_channel(t_left + red_term);
      g1 = clamp_channel(t_left + green_term);
      b1 = clamp_channel(t_left + blue_term);
      r2 = clamp_channel(t_right + red_term);
      g2 = clamp_channel(t_right + green_term);
      b2 = clamp_channel(t_right + blue_term);
      case (order)
         ORDER_BGRA: begin
            word.pixels     = {8'hFF, r2, g2, b2, 8'hFF, r1, g1, b1};
            word.byte_count = BYTES_FULL;
         end
         ORDER_RGB: begin
            word.pixels     = {16'h0000, b2, g2, r2, b1, g1, r1};
            word.byte_count = BYTES_RGB;
         end
         default: begin
            word.pixels     = {8'hFF, b2, g2, r2, 8'hFF, b1, g1, r1};
            word.byte_count = BYTES_FULL;
         end
      endcase
      return word;
   endfunction

   always @(posedge clock) begin
      rgb_word_type got;
      rgb_word_type want;
      logic [15:0] chroma_pair;
      if (reset) begin
         row_width = ROW_WIDTH_RESET;
         out_order = ORDER_BGRA;
         pair_col  = 0;
         odd_row   = 1'b0;
         expected_words.delete();
      end else begin
         // Track register writes
         if (csr_we) begin
            if (csr_addr == REG_ROW_WIDTH) begin
               row_width = csr_wdata;
            end else if (csr_addr == REG_OUTPUT_ORDER) begin
               out_order = csr_wdata[ORDER_W-1:0];
            end
         end

         // Compare each accepted pixel item with the oldest prediction
         if (rsp_tvalid && rsp_tready) begin
            got.pixels     = rsp_tdata[63:0];
            got.byte_count = rsp_tdata[67:64];
            if (expected_words.size() == 0) begin
               report_mismatch($sformatf("pixel item %h with none expected", rsp_tdata));
            end else begin
               want = expected_words.pop_front();
               if (got.pixels !== want.pixels) begin
                  report_mismatch($sformatf("pixel_bytes %h, expected %h",
                                            got.pixels, want.pixels));
               end
               if (got.byte_count !== want.byte_count) begin
                  report_mismatch($sformatf("byte_count %0d, expected %0d",
                                            got.byte_count, want.byte_count));
               end
            end
         end

         // Predict each accepted pair: store chroma on even rows, reuse on odd
         if (req_tvalid && req_tready) begin
            if (req_tuser) begin
               pair_col = 0;
               odd_row  = 1'b0;
            end
            if (!odd_row) begin
               chroma_line[pair_col] = {req_tdata[23:16], req_tdata[31:24]};
            end
            chroma_pair = chroma_line[pair_col];
            expected_words.push_back(convert_pair(req_tdata[7:0], req_tdata[15:8],
                                                  chroma_pair[15:8], chroma_pair[7:0],
                                                  out_order));
            pair_col++;
            if (pair_col >= row_pairs(row_width)) begin
               pair_col = 0;
               odd_row  = ~odd_row;
            end
         end
      end
      waiting = expected_words.size();
   end

endmodule

// ===== test/tb_nv21_to_rgb_converter.sv =====
`timescale 1ns / 1ps

module tb_nv21_to_rgb_converter;

   import n2r_pkg::*;

   localparam int CLOCK_PERIOD = 12;
   localparam int SETTLE_CYCLES = 16;
   localparam int HOLD_CYCLES = 200;
   localparam int LIMIT_NS = 4_000_000;
   localparam logic [ORDER_W-1:0] ORDER_RESERVED = 2'd3;

   logic                    clock = 1'b0;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [31:0]             req_tdata;   // luma_first, luma_second, chroma_v, chroma_u
   logic                    req_tuser;   // frame_start
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [71:0]             rsp_tdata;   // pixel_bytes, byte_count, 4 zero bits
   logic                    csr_we;
   logic [REG_INDEX_W-1:0]  csr_addr;
   logic [CSR_DATA_W-1:0]   csr_wdata;

   int mismatch_count;
   int outstanding;
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit hold_start = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   nv21_to_rgb_converter dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   nv21_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_we         (csr_we),
      .csr_addr       (csr_addr),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // Abort a hung run
   initial begin
      #(LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // Drive pixel-side ready: random stalls, or a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            for (int k = 0; k < HOLD_CYCLES; k++) begin
               rsp_tready <= 1'b0;
               @(negedge clock);
            end
         end
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Bias samples toward the range ends and the neutral points
   function automatic logic [7:0] pick_sample();
      case ($urandom_range(9))
         0: return 8'd0;
         1: return 8'd255;
         2: return 8'd16;
         3: return 8'd235;
         4: return 8'd128;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // Offer one pair after random idle cycles and hold it until taken
   task automatic send_pair(input logic [7:0] luma_first, input logic [7:0] luma_second,
                            input logic [7:0] chroma_v, input logic [7:0] chroma_u,
                            input logic frame_start);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {chroma_u, chroma_v, luma_second, luma_first};
      req_tuser  <= frame_start;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Drop valid and wait until every pixel item has come back
   task automatic drain();
      req_tvalid <= 1'b0;
      do @(negedge clock); while (outstanding != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input logic [REG_INDEX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_format(input logic [ROW_WIDTH_W-1:0] width,
                             input logic [ORDER_W-1:0] order);
      write_reg(REG_ROW_WIDTH, width);
      write_reg(REG_OUTPUT_ORDER, CSR_DATA_W'(order));
   endtask

   // Stream random pairs; open a frame first where the row may have grown
   task automatic run_phase(input int n_items, input int send_pct, input int hold_pct,
                            input bit open_frame, input bit pressure);
      logic frame_start;
      send_idle_pct = send_pct;
      stall_pct     = hold_pct;
      for (int i = 0; i < n_items; i++) begin
         frame_start = (open_frame && i == 0) || ($urandom_range(99) < 2);
         if (pressure && i == n_items / 3) begin
            hold_start = 1'b1;
         end
         if (pressure && i == (2 * n_items) / 3) begin
            drain();
         end
         send_pair(pick_sample(), pick_sample(), pick_sample(), pick_sample(), frame_start);
      end
      drain();
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      csr_we     = 1'b0;
      csr_addr   = REG_ROW_WIDTH;
      csr_wdata  = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: two pairs per row, extremes, chroma reuse, frame restarts
      set_format(13'd4, ORDER_BGRA);
      send_pair(8'd0,   8'd255, 8'd128, 8'd128, 1'b1);
      send_pair(8'd16,  8'd235, 8'd0,   8'd0,   1'b0);
      send_pair(8'd255, 8'd0,   8'd255, 8'd255, 1'b0);
      send_pair(8'd128, 8'd128, 8'd17,  8'd200, 1'b0);
      send_pair(8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
      send_pair(8'd0,   8'd0,   8'd0,   8'd255, 1'b0);
      send_pair(8'd235, 8'd16,  8'd128, 8'd0,   1'b0);
      send_pair(8'd100, 8'd200, 8'd0,   8'd0,   1'b0);
      send_pair(8'd16,  8'd16,  8'd255, 8'd0,   1'b0);
      send_pair(8'd90,  8'd180, 8'd60,  8'd240, 1'b1);
      send_pair(8'd50,  8'd60,  8'd0,   8'd255, 1'b0);
      send_pair(8'd255, 8'd0,   8'd7,   8'd9,   1'b0);
      send_pair(8'd0,   8'd255, 8'd1,   8'd2,   1'b1);
      send_pair(8'd81,  8'd145, 8'd90,  8'd54,  1'b0);
      send_pair(8'd200, 8'd30,  8'd11,  8'd22,  1'b0);
      send_pair(8'd128, 8'd64,  8'd33,  8'd44,  1'b0);
      drain();

      // Narrow rows through every byte order and idle pattern
      set_format(13'd2, ORDER_RGB);
      run_phase(200, 0, 0, 1'b1, 1'b0);
      set_format(13'd0, ORDER_RGBA);
      run_phase(150, 70, 0, 1'b1, 1'b0);
      set_format(13'd7, ORDER_RESERVED);
      run_phase(200, 0, 70, 1'b1, 1'b0);
      set_format(13'd64, ORDER_BGRA);
      run_phase(300, 28, 28, 1'b1, 1'b1);

      // Widest row, then shrink mid-row so the row ends early
      set_format(13'd4096, ORDER_RGB);
      run_phase(60, 0, 0, 1'b1, 1'b0);
      write_reg(REG_ROW_WIDTH, 13'd6);
      run_phase(150, 28, 28, 1'b0, 1'b0);

      // Oversized width, then shrink to below one pair
      set_format(13'd8191, ORDER_RGBA);
      run_phase(50, 0, 0, 1'b1, 1'b0);
      write_reg(REG_ROW_WIDTH, 13'd1);
      run_phase(150, 70, 28, 1'b0, 1'b0);

      // Reset width and a short even width under heavy idling
      set_format(ROW_WIDTH_RESET, ORDER_BGRA);
      run_phase(400, 28, 28, 1'b1, 1'b0);
      set_format(13'd12, ORDER_RGBA);
      run_phase(300, 70, 70, 1'b1, 1'b0);

      if (mismatch_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/n2r_pkg.sv
rtl/n2r_front.sv
rtl/n2r_queue.sv
rtl/n2r_back.sv
rtl/nv21_to_rgb_converter.sv
test/nv21_checker.sv
test/tb_nv21_to_rgb_converter.sv
